// ===== hw/rtl/hashed_rx_filter_table_defines.svh =====
// Assertion macros shared by the filter table RTL.
`ifndef HASHED_RX_FILTER_TABLE_DEFINES_SVH
`define HASHED_RX_FILTER_TABLE_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define HRFT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define HRFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hrft_pkg.sv =====
// Types and constants shared by the filter table modules.
package hrft_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_BUSY    = 3'd2;
    localparam logic [2:0] ST_EXISTS  = 3'd3;
    localparam logic [2:0] ST_PERM    = 3'd4;
    localparam logic [2:0] ST_NOENT   = 3'd5;

    localparam logic [0:0] REG_IP_PRESENT  = 1'd0;
    localparam logic [0:0] REG_MAC_PRESENT = 1'd1;

    localparam logic [15:0] HASH_SEED = 16'h1fff;
    localparam int unsigned FUDGE_FULL = 1;
    localparam int unsigned FUDGE_WILD = 3;

    // Stored filter entry: type, match words, priority, queue, flags.
    typedef struct packed {
        logic [2:0]  ftype;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [2:0]  prio;
        logic [11:0] queue;
        logic [2:0]  flags;
    } entry_t;

    // Result beat.
    typedef struct packed {
        logic [13:0] cleared_count;
        logic [7:0]  search_limit;
        logic        limit_changed;
        logic [7:0]  probe_depth;
        logic [12:0] entry_index;
        logic        table_select;
        logic [2:0]  status;
    } result_t;

    // First probe slot from the 16-bit LFSR hash of the key.
    function automatic logic [15:0] lfsr_hash(input logic [31:0] key);
        logic [15:0] h;
        h = HASH_SEED ^ key[31:16];
        h = h ^ (h >> 3) ^ (h >> 6);
        h = h ^ (h >> 9);
        h = h ^ (h << 13) ^ key[15:0];
        h = h ^ (h >> 3) ^ (h >> 6);
        return h ^ (h >> 9);
    endfunction

endpackage

// ===== hw/rtl/hrft_table_mem.sv =====
// One filter table: entry memory plus a valid-bit memory, registered reads.
module hrft_table_mem
    import hrft_pkg::*;
#(
    parameter int ENTRIES = 512
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [$clog2(ENTRIES)-1:0] rd_addr,
    output entry_t                     rd_entry,
    output logic                       rd_valid,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  entry_t                     wr_entry,
    input  logic                       wr_valid,
    input  logic                       vwr_en,
    input  logic [$clog2(ENTRIES)-1:0] vwr_addr
);

    entry_t mem_entry [ENTRIES];
    logic   mem_valid [ENTRIES];

    // Write entry data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_entry[wr_addr] <= wr_entry;
        end
    end

    // Write valid bit; the clearing pass and the sequencer share this port.
    always_ff @(posedge clk)
    begin
        if (vwr_en)
        begin
            mem_valid[vwr_addr] <= wr_valid;
        end
    end

    // Registered read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry <= mem_entry[rd_addr];
            rd_valid <= mem_valid[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/hashed_rx_filter_table.sv =====
// Top level of the receive filter table manager.
// hashed_rx_filter_table keeps two open-addressed hash tables (IP and MAC) in
// on-chip memories and serves one insert, remove or clear request at a time.
// After reset a clearing pass walks the valid bits of both tables, one slot
// per cycle up to the size of the larger table; no request is taken
// meanwhile, configuration writes are. An insert or remove passes accept and
// setup, then reads and compares one slot per probe, then gives the result;
// when the chain is full the search reads one slot past the limit, so at most
// MAX_PROBES+1 slots. A bad or refused request goes from setup to the result.
// A clear walks every slot of each present table, reading and then checking
// each slot. Request tdata fields from bit 0: op, filter_type, match words,
// priority, replace, queue, rss, scatter, override. Result tdata: status,
// table_select, entry_index, probe_depth, limit_changed, search_limit,
// cleared_count.
module hashed_rx_filter_table
    import hrft_pkg::*;
#(
    parameter int IP_TABLE_ENTRIES  = 8192,
    parameter int MAC_TABLE_ENTRIES = 512,
    parameter int MAX_PROBES        = 200
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0], filter_type[4:2], match_word0[36:5], match_word1[68:37],
    // match_word2[100:69], priority_req[103:101], replace_allowed[104],
    // queue_id[116:105], rss_enable[117], scatter_enable[118],
    // override_ip[119]
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], table_select[3], entry_index[16:4], probe_depth[24:17],
    // limit_changed[25], search_limit[33:26], cleared_count[47:34]
    output logic [47:0]  m_axis_tdata
);

`include "hashed_rx_filter_table_defines.svh"

    localparam int IPW  = $clog2(IP_TABLE_ENTRIES);
    localparam int MACW = $clog2(MAC_TABLE_ENTRIES);
    localparam int BIGW = (IPW > MACW) ? IPW : MACW;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_PREAD, S_PCHECK, S_CREAD, S_CCHECK,
        S_CNEXT, S_RESULT
    } state_t;

    state_t      state_reg;
    logic        ip_present_reg, mac_present_reg;
    logic [BIGW:0] init_cnt_reg;

    logic [1:0]  op_reg;
    logic [2:0]  type_reg;
    logic [31:0] w0_reg, w1_reg, w2_reg;
    logic [2:0]  prio_reg;
    logic        repl_reg;
    logic [11:0] queue_reg;
    logic [2:0]  flags_reg;
    logic        tsel_reg;
    logic [15:0] idx_reg, incr_reg;
    logic [7:0]  depth_reg;
    logic [14:0] ip_used_reg;
    logic [10:0] mac_used_reg;
    logic [7:0]  tdepth_reg [6];
    logic [13:0] ccount_reg;
    logic [BIGW:0] scan_reg;
    logic        ctab_reg;

    result_t     res_reg;
    logic        out_valid_reg;

    // Memory ports
    logic   ip_rd_en, mac_rd_en, ip_wr_en, mac_wr_en, ip_vwr_en, mac_vwr_en;
    logic   ip_rvalid, mac_rvalid, wr_valid;
    entry_t ip_rentry, mac_rentry, wr_entry;
    logic [IPW-1:0]  ip_raddr, ip_waddr;
    logic [MACW-1:0] mac_raddr, mac_waddr;

    hrft_table_mem #(.ENTRIES(IP_TABLE_ENTRIES)) u_ip_mem (
        .clk(clk), .rd_en(ip_rd_en), .rd_addr(ip_raddr), .rd_entry(ip_rentry),
        .rd_valid(ip_rvalid), .wr_en(ip_wr_en), .wr_addr(ip_waddr),
        .wr_entry(wr_entry), .wr_valid(wr_valid), .vwr_en(ip_vwr_en),
        .vwr_addr(ip_waddr)
    );

    hrft_table_mem #(.ENTRIES(MAC_TABLE_ENTRIES)) u_mac_mem (
        .clk(clk), .rd_en(mac_rd_en), .rd_addr(mac_raddr), .rd_entry(mac_rentry),
        .rd_valid(mac_rvalid), .wr_en(mac_wr_en), .wr_addr(mac_waddr),
        .wr_entry(wr_entry), .wr_valid(wr_valid), .vwr_en(mac_vwr_en),
        .vwr_addr(mac_waddr)
    );

    // Configuration port
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_IP_PRESENT:  prdata[0] = ip_present_reg;
            REG_MAC_PRESENT: prdata[0] = mac_present_reg;
            default:         prdata = '0;
        endcase
        if (paddr[1:0] != 2'd0)
        begin
            prdata = '0;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg;

    // Read-data view of the selected table
    logic   cur_tab;
    entry_t rd_e;
    logic   rd_v;
    assign cur_tab = (state_reg == S_CREAD || state_reg == S_CCHECK ||
                      state_reg == S_CNEXT) ? ctab_reg : tsel_reg;
    assign rd_e = cur_tab ? mac_rentry : ip_rentry;
    assign rd_v = cur_tab ? mac_rvalid : ip_rvalid;

    logic [15:0] ip_mask16, mac_mask16, mask16, idx_m;
    assign ip_mask16  = 16'((32'd1 << IPW) - 1);
    assign mac_mask16 = 16'((32'd1 << MACW) - 1);
    assign mask16 = tsel_reg ? mac_mask16 : ip_mask16;
    assign idx_m  = idx_reg & mask16;

    logic hit;
    assign hit = rd_v && rd_e.ftype == type_reg && rd_e.w0 == w0_reg &&
                 rd_e.w1 == w1_reg && rd_e.w2 == w2_reg;

    // Memory control
    always_comb
    begin
        ip_rd_en  = 1'b0;
        mac_rd_en = 1'b0;
        ip_raddr  = idx_m[IPW-1:0];
        mac_raddr = idx_m[MACW-1:0];
        ip_wr_en  = 1'b0;
        mac_wr_en = 1'b0;
        ip_vwr_en = 1'b0;
        mac_vwr_en = 1'b0;
        ip_waddr  = idx_m[IPW-1:0];
        mac_waddr = idx_m[MACW-1:0];
        wr_valid  = 1'b0;
        wr_entry  = '{ftype: type_reg, w0: w0_reg, w1: w1_reg, w2: w2_reg,
                      prio: prio_reg, queue: queue_reg, flags: flags_reg};
        unique case (state_reg)
            S_INIT:
            begin
                ip_waddr  = init_cnt_reg[IPW-1:0];
                mac_waddr = init_cnt_reg[MACW-1:0];
                ip_vwr_en  = (init_cnt_reg < (BIGW+1)'(IP_TABLE_ENTRIES));
                mac_vwr_en = (init_cnt_reg < (BIGW+1)'(MAC_TABLE_ENTRIES));
            end
            S_PREAD:
            begin
                ip_rd_en  = !tsel_reg;
                mac_rd_en = tsel_reg;
            end
            S_PCHECK:
            begin
                if (op_reg == OP_INSERT && depth_reg <= 8'(MAX_PROBES) &&
                    (!rd_v || (hit && repl_reg && prio_reg >= rd_e.prio)))
                begin
                    wr_valid   = 1'b1;
                    ip_wr_en   = !tsel_reg;
                    mac_wr_en  = tsel_reg;
                    ip_vwr_en  = !tsel_reg;
                    mac_vwr_en = tsel_reg;
                end
                else if (op_reg == OP_REMOVE && depth_reg <= 8'(MAX_PROBES) &&
                         hit && prio_reg >= rd_e.prio)
                begin
                    ip_vwr_en  = !tsel_reg;
                    mac_vwr_en = tsel_reg;
                end
            end
            S_CREAD:
            begin
                ip_raddr  = scan_reg[IPW-1:0];
                mac_raddr = scan_reg[MACW-1:0];
                ip_rd_en  = !ctab_reg;
                mac_rd_en = ctab_reg;
            end
            S_CCHECK:
            begin
                ip_waddr  = scan_reg[IPW-1:0];
                mac_waddr = scan_reg[MACW-1:0];
                if (rd_v && rd_e.prio <= prio_reg)
                begin
                    ip_vwr_en  = !ctab_reg;
                    mac_vwr_en = ctab_reg;
                end
            end
            default:
            begin
                ip_rd_en = 1'b0;
            end
        endcase
    end

    // Search key of the held request
    logic [31:0] key_c;
    logic        bit_c;
    logic [2:0]  in_type;
    assign in_type = s_axis_tdata[4:2];
    assign bit_c = (type_reg == 3'd2 || type_reg == 3'd3 || type_reg == 3'd5);
    assign key_c = w0_reg ^ w1_reg ^ w2_reg ^ {31'd0, bit_c};

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            ip_present_reg  <= 1'b0;
            mac_present_reg <= 1'b0;
            init_cnt_reg    <= '0;
            ip_used_reg     <= '0;
            mac_used_reg    <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                tdepth_reg[i] <= '0;
            end
        end
        else
        begin
            if (psel && penable && pwrite && paddr[1:0] == 2'd0)
            begin
                unique case (paddr[2])
                    REG_IP_PRESENT:  ip_present_reg  <= pwdata[0];
                    REG_MAC_PRESENT: mac_present_reg <= pwdata[0];
                    default:         ip_present_reg  <= ip_present_reg;
                endcase
            end
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + 1'b1;
                    if (init_cnt_reg == (BIGW+1)'((1 << BIGW) - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        op_reg    <= s_axis_tdata[1:0];
                        type_reg  <= s_axis_tdata[4:2];
                        w0_reg    <= s_axis_tdata[36:5];
                        w1_reg    <= s_axis_tdata[68:37];
                        w2_reg    <= s_axis_tdata[100:69];
                        prio_reg  <= s_axis_tdata[103:101];
                        repl_reg  <= s_axis_tdata[104];
                        queue_reg <= s_axis_tdata[116:105];
                        flags_reg <= s_axis_tdata[119:117];
                        tsel_reg  <= in_type[2];
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    res_reg   <= '0;
                    depth_reg <= 8'd1;
                    idx_reg  <= lfsr_hash(key_c);
                    incr_reg <= {key_c[14:0], 1'b0} - 16'd1;
                    if (op_reg == OP_CLEAR)
                    begin
                        ccount_reg <= '0;
                        scan_reg   <= '0;
                        ctab_reg   <= 1'b0;
                        state_reg  <= ip_present_reg ? S_CREAD : S_CNEXT;
                    end
                    else if (op_reg != OP_INSERT && op_reg != OP_REMOVE ||
                             type_reg > 3'd5)
                    begin
                        res_reg.status <= ST_INVALID;
                        state_reg <= S_RESULT;
                    end
                    else if (!(tsel_reg ? mac_present_reg : ip_present_reg))
                    begin
                        res_reg.status <= ST_INVALID;
                        res_reg.table_select <= tsel_reg;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_PREAD;
                    end
                end
                S_PREAD:
                begin
                    state_reg <= S_PCHECK;
                end
                S_PCHECK:
                begin
                    if (depth_reg <= 8'(MAX_PROBES) && rd_v && !hit)
                    begin
                        idx_reg   <= (idx_reg + incr_reg) & mask16;
                        depth_reg <= depth_reg + 1'b1;
                        state_reg <= S_PREAD;
                    end
                    else
                    begin
                        res_reg.table_select <= tsel_reg;
                        res_reg.entry_index  <= 13'(idx_m);
                        res_reg.probe_depth  <= depth_reg;
                        state_reg <= S_RESULT;
                        if (op_reg == OP_INSERT)
                        begin
                            if (depth_reg > 8'(MAX_PROBES))
                            begin
                                res_reg.status <= ST_BUSY;
                            end
                            else if (hit && !repl_reg)
                            begin
                                res_reg.status <= ST_EXISTS;
                            end
                            else if (hit && prio_reg < rd_e.prio)
                            begin
                                res_reg.status <= ST_PERM;
                            end
                            else
                            begin
                                if (!hit)
                                begin
                                    if (tsel_reg)
                                        mac_used_reg <= mac_used_reg + 1'b1;
                                    else
                                        ip_used_reg <= ip_used_reg + 1'b1;
                                end
                                if (tdepth_reg[type_reg] < depth_reg)
                                begin
                                    tdepth_reg[type_reg] <= depth_reg;
                                    res_reg.limit_changed <= 1'b1;
                                    res_reg.search_limit <= depth_reg + (type_reg[0] ?
                                        8'(FUDGE_WILD) : 8'(FUDGE_FULL));
                                end
                            end
                        end
                        else
                        begin
                            if (!hit || depth_reg > 8'(MAX_PROBES))
                            begin
                                res_reg.status <= ST_NOENT;
                            end
                            else if (prio_reg < rd_e.prio)
                            begin
                                res_reg.status <= ST_PERM;
                            end
                            else
                            begin
                                res_reg.probe_depth <= '0;
                                if (tsel_reg)
                                begin
                                    mac_used_reg <= mac_used_reg - 1'b1;
                                    if (mac_used_reg == 11'd1)
                                    begin
                                        tdepth_reg[4] <= '0;
                                        tdepth_reg[5] <= '0;
                                    end
                                end
                                else
                                begin
                                    ip_used_reg <= ip_used_reg - 1'b1;
                                    if (ip_used_reg == 15'd1)
                                    begin
                                        for (int i = 0; i < 4; i++)
                                            tdepth_reg[i] <= '0;
                                    end
                                end
                            end
                        end
                    end
                end
                S_CREAD:
                begin
                    state_reg <= S_CCHECK;
                end
                S_CCHECK:
                begin
                    if (rd_v && rd_e.prio <= prio_reg)
                    begin
                        ccount_reg <= ccount_reg + 1'b1;
                        if (ctab_reg)
                            mac_used_reg <= mac_used_reg - 1'b1;
                        else
                            ip_used_reg <= ip_used_reg - 1'b1;
                    end
                    if (scan_reg == (BIGW+1)'((ctab_reg ? MAC_TABLE_ENTRIES :
                                                IP_TABLE_ENTRIES) - 1))
                    begin
                        state_reg <= S_CNEXT;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_CREAD;
                    end
                end
                S_CNEXT:
                begin
                    scan_reg <= '0;
                    if (!ctab_reg)
                    begin
                        if (ip_used_reg == '0)
                        begin
                            for (int i = 0; i < 4; i++)
                                tdepth_reg[i] <= '0;
                        end
                        ctab_reg  <= 1'b1;
                        state_reg <= mac_present_reg ? S_CREAD : S_CNEXT;
                    end
                    else
                    begin
                        if (mac_used_reg == '0)
                        begin
                            tdepth_reg[4] <= '0;
                            tdepth_reg[5] <= '0;
                        end
                        res_reg.cleared_count <= ccount_reg;
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `HRFT_ASSERT_IMP(a_no_accept_busy, clk, rst_n, s_axis_tready, !out_valid_reg,
        "request accepted while a result waits")
    `HRFT_ASSERT_NEXT(a_result_valid, clk, rst_n, state_reg == S_RESULT, out_valid_reg,
        "result not presented")
    `HRFT_ASSERT_IMP(a_one_table_write, clk, rst_n, state_reg != S_INIT,
        !(ip_vwr_en && mac_vwr_en), "both tables written at once")
    `HRFT_ASSERT_IMP(a_depth_bound, clk, rst_n, state_reg == S_PCHECK,
        depth_reg <= 8'(MAX_PROBES + 1), "probe depth beyond bound")

endmodule

// ===== bench/hashed_rx_filter_table_checker.sv =====
// Result checker for the receive filter table: tracks config, predicts and compares.
module hashed_rx_filter_table_checker
    import hrft_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    // op, filter_type, match_word0..2, priority_req, replace_allowed,
    // queue_id, rss_enable, scatter_enable, override_ip
    input  logic [119:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, table_select, entry_index, probe_depth, limit_changed,
    // search_limit, cleared_count
    input  logic [47:0]  m_axis_tdata,
    output int           fail_count,
    output int           pending_results
);

    localparam int IP_SLOTS   = 8192;
    localparam int MAC_SLOTS  = 512;
    localparam int MAC_BASE   = IP_SLOTS;
    localparam int PROBE_MAX  = 200;

    // Both tables share one store; the MAC table starts at MAC_BASE.
    entry_t      slot_store [0:IP_SLOTS+MAC_SLOTS-1];
    bit          slot_valid [0:IP_SLOTS+MAC_SLOTS-1];
    int          used_slots [0:1];
    bit          table_on   [0:1];
    int          type_depth [0:5];
    result_t     expected_results [$];
    int          fails;

    initial
    begin
        for (int i = 0; i < IP_SLOTS + MAC_SLOTS; i++)
            slot_valid[i] = 1'b0;
        for (int i = 0; i < 6; i++)
            type_depth[i] = 0;
        used_slots[0] = 0;
        used_slots[1] = 0;
        table_on[0] = 1'b0;
        table_on[1] = 1'b0;
        fails = 0;
        fail_count = 0;
        pending_results = 0;
    end

    // Zero the search depths of every filter type held by one table.
    task automatic zero_depths(input int tb);
        if (tb == 0)
            for (int i = 0; i < 4; i++)
                type_depth[i] = 0;
        else
        begin
            type_depth[4] = 0;
            type_depth[5] = 0;
        end
    endtask

    // Compute the result of one request beat and update the table image.
    task automatic predict_filter_op(input logic [119:0] d, output result_t r);
        logic [1:0]  op;
        logic [2:0]  ft;
        logic [2:0]  prio;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] key;
        logic [31:0] step32;
        logic [15:0] h;
        logic        repl;
        int          tb;
        int          base;
        int          mask;
        int          idx;
        int          depth;
        int          dropped;
        bit          found;
        entry_t      e;
        op = d[1:0];
        ft = d[4:2];
        w0 = d[36:5];
        w1 = d[68:37];
        w2 = d[100:69];
        prio = d[103:101];
        repl = d[104];
        r = '0;
        if (op == OP_CLEAR)
        begin
            dropped = 0;
            for (tb = 0; tb < 2; tb++)
            begin
                base = (tb == 0) ? 0 : MAC_BASE;
                if (table_on[tb])
                    for (int i = 0; i < ((tb == 0) ? IP_SLOTS : MAC_SLOTS); i++)
                        if (slot_valid[base+i] && slot_store[base+i].prio <= prio)
                        begin
                            slot_valid[base+i] = 1'b0;
                            used_slots[tb]--;
                            dropped++;
                        end
                if (used_slots[tb] == 0)
                    zero_depths(tb);
            end
            r.cleared_count = dropped[13:0];
        end
        else if (op != OP_INSERT && op != OP_REMOVE || ft > 3'd5)
            r.status = ST_INVALID;
        else
        begin
            tb = int'(ft[2]);
            r.table_select = ft[2];
            if (!table_on[tb])
                r.status = ST_INVALID;
            else
            begin
                base = (tb == 0) ? 0 : MAC_BASE;
                mask = ((tb == 0) ? IP_SLOTS : MAC_SLOTS) - 1;
                key = w0 ^ w1 ^ w2 ^ {31'd0, (ft == 3'd2 || ft == 3'd3 || ft == 3'd5)};
                step32 = key * 2 - 1;
                // LFSR hash of the key, seeded with the upper half
                h = HASH_SEED ^ key[31:16];
                h = h ^ (h >> 3) ^ (h >> 6);
                h = h ^ (h >> 9);
                h = h ^ (h << 13) ^ key[15:0];
                h = h ^ (h >> 3) ^ (h >> 6);
                h = h ^ (h >> 9);
                idx = h & mask;
                depth = 1;
                found = 1'b0;
                // Walk the probe chain until a free slot, a match or the limit
                while (!found && depth <= PROBE_MAX && slot_valid[base+idx])
                begin
                    e = slot_store[base+idx];
                    if (e.ftype == ft && e.w0 == w0 && e.w1 == w1 && e.w2 == w2)
                        found = 1'b1;
                    else
                    begin
                        idx = (idx + step32[15:0]) & mask;
                        depth++;
                    end
                end
                r.entry_index = idx[12:0];
                r.probe_depth = depth[7:0];
                if (op == OP_INSERT)
                begin
                    if (!found && depth > PROBE_MAX)
                        r.status = ST_BUSY;
                    else if (found && !repl)
                        r.status = ST_EXISTS;
                    else if (found && prio < slot_store[base+idx].prio)
                        r.status = ST_PERM;
                    else
                    begin
                        if (!found)
                        begin
                            slot_valid[base+idx] = 1'b1;
                            used_slots[tb]++;
                        end
                        e.ftype = ft;
                        e.w0 = w0;
                        e.w1 = w1;
                        e.w2 = w2;
                        e.prio = prio;
                        e.queue = d[116:105];
                        e.flags = d[119:117];
                        slot_store[base+idx] = e;
                        if (type_depth[ft] < depth)
                        begin
                            type_depth[ft] = depth;
                            r.limit_changed = 1'b1;
                            r.search_limit = 8'(depth + (ft[0] ? FUDGE_WILD : FUDGE_FULL));
                        end
                    end
                end
                else if (!found)
                    r.status = ST_NOENT;
                else if (prio < slot_store[base+idx].prio)
                    r.status = ST_PERM;
                else
                begin
                    slot_valid[base+idx] = 1'b0;
                    used_slots[tb]--;
                    if (used_slots[tb] == 0)
                        zero_depths(tb);
                    r.probe_depth = '0;
                end
            end
        end
    endtask

    // Report one field that differs from its prediction.
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    // Watch config writes, request beats and result beats.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_IP_PRESENT)
                    table_on[0] = pwdata[0];
                else
                    table_on[1] = pwdata[0];
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result beat with no request waiting, actual %h",
                             $time, m_axis_tdata);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("table_select", want.table_select, got.table_select);
                    check_field("entry_index", want.entry_index, got.entry_index);
                    check_field("probe_depth", want.probe_depth, got.probe_depth);
                    check_field("limit_changed", want.limit_changed, got.limit_changed);
                    check_field("search_limit", want.search_limit, got.search_limit);
                    check_field("cleared_count", want.cleared_count, got.cleared_count);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_filter_op(s_axis_tdata, want);
                expected_results.push_back(want);
            end
            fail_count <= fails;
            pending_results <= expected_results.size();
        end
    end

endmodule

// ===== bench/hashed_rx_filter_table_tb.sv =====
// Testbench top for the receive filter table: stimulus, flow control and verdict.
module hashed_rx_filter_table_tb;
    import hrft_pkg::*;

    typedef struct {
        logic [2:0]  ft;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
    } filter_key_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // op, filter_type, match_word0..2, priority_req, replace_allowed,
    // queue_id, rss_enable, scatter_enable, override_ip
    logic [119:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // status, table_select, entry_index, probe_depth, limit_changed,
    // search_limit, cleared_count
    logic [47:0]  m_axis_tdata;
    int           fail_count;
    int           pending_results;

    filter_key_t  known_filters [$];
    logic [31:0]  hot_key;
    int           burst_left = 0;
    bit           hold_request = 1'b0;
    bit           hold_done = 1'b0;
    int           pattern_left = 0;
    int           stall_pct = 0;

    hashed_rx_filter_table i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hashed_rx_filter_table_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bound the run time.
    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    // Drive the result ready with a changing stall rate and one long hold-off.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_left = $urandom_range(8, 64);
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        default: stall_pct = 75;
                    endcase
                end
                pattern_left--;
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Pack one request beat.
    function automatic logic [119:0] pack_request(
        input logic [1:0] op, input logic [2:0] ft, input logic [31:0] w0,
        input logic [31:0] w1, input logic [31:0] w2, input logic [2:0] prio,
        input logic repl, input logic [11:0] queue, input logic [2:0] flags);
        return {flags, queue, repl, prio, w2, w1, w0, ft, op};
    endfunction

    // Offer one beat, with random bursts and gaps, and hold until accepted.
    task automatic send_beat(input logic [119:0] d);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (d[1:0] == OP_INSERT && d[4:2] <= 3'd5)
        begin
            known_filters.push_back('{d[4:2], d[36:5], d[68:37], d[100:69]});
            if (known_filters.size() > 300)
                void'(known_filters.pop_front());
        end
    endtask

    // Drop valid and wait until every result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write one register through the config port.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_tables(input logic ip_on, input logic mac_on);
        drain_results();
        write_reg(REG_IP_PRESENT, {31'd0, ip_on});
        write_reg(REG_MAC_PRESENT, {31'd0, mac_on});
    endtask

    // Build a random request: mostly known filters and colliding keys.
    task automatic random_beat(output logic [119:0] d);
        logic [1:0]  op;
        logic [2:0]  ft;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        int          pick;
        filter_key_t k;
        pick = $urandom_range(0, 999);
        if (pick < 8)
            op = OP_CLEAR;
        else if (pick < 30)
            op = 2'd3;
        else if (pick < 600)
            op = OP_INSERT;
        else
            op = OP_REMOVE;
        ft = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7)) :
                                            3'($urandom_range(0, 5));
        w0 = $urandom;
        w1 = $urandom;
        w2 = $urandom;
        pick = $urandom_range(0, 99);
        if (known_filters.size() != 0 && pick < ((op == OP_REMOVE) ? 70 : 35))
        begin
            k = known_filters[$urandom_range(0, known_filters.size() - 1)];
            ft = k.ft;
            w0 = k.w0;
            w1 = k.w1;
            w2 = k.w2;
        end
        else if (pick < 75)
            w2 = hot_key ^ w0 ^ w1;
        d = pack_request(op, ft, w0, w1, w2, 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                         3'($urandom_range(0, 7)));
    endtask

    initial
    begin
        logic [119:0] d;
        hot_key = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Both tables absent after reset: inserts, removes and the bad op are refused
        send_beat(pack_request(OP_INSERT, 3'd0, '0, '0, '0, 3'd0, 1'b0, '0, '0));
        send_beat(pack_request(OP_REMOVE, 3'd4, '1, '1, '1, 3'd7, 1'b1, '1, '1));
        send_beat(pack_request(OP_CLEAR, 3'd0, '0, '0, '0, 3'd7, 1'b0, '0, '0));
        send_beat(pack_request(2'd3, 3'd1, '0, '0, '0, 3'd0, 1'b0, '0, '0));
        set_tables(1'b1, 1'b1);

        // Bad types, insert/replace/priority/remove on one filter, then more inserts and clears
        send_beat(pack_request(OP_INSERT, 3'd6, '1, '0, '1, 3'd7, 1'b1, '1, '1));
        send_beat(pack_request(OP_REMOVE, 3'd7, '0, '1, '0, 3'd0, 1'b0, '0, '0));
        send_beat(pack_request(OP_INSERT, 3'd0, '0, '0, '0, 3'd3, 1'b0, '1, '1));
        send_beat(pack_request(OP_INSERT, 3'd0, '0, '0, '0, 3'd3, 1'b0, '0, '0));
        send_beat(pack_request(OP_INSERT, 3'd0, '0, '0, '0, 3'd2, 1'b1, '0, '0));
        send_beat(pack_request(OP_INSERT, 3'd0, '0, '0, '0, 3'd7, 1'b1, 12'd5, 3'd2));
        send_beat(pack_request(OP_REMOVE, 3'd0, '0, '0, '0, 3'd3, 1'b0, '0, '0));
        send_beat(pack_request(OP_REMOVE, 3'd0, '0, '0, '0, 3'd7, 1'b0, '0, '0));
        send_beat(pack_request(OP_REMOVE, 3'd0, '0, '0, '0, 3'd7, 1'b0, '0, '0));
        send_beat(pack_request(OP_INSERT, 3'd5, '1, '1, '1, 3'd0, 1'b0, '0, '0));
        send_beat(pack_request(OP_INSERT, 3'd1, 32'h1, 32'h2, 32'h3, 3'd4, 1'b0, '0, '0));
        send_beat(pack_request(OP_INSERT, 3'd2, 32'h1, 32'h2, 32'h3, 3'd0, 1'b0, '0, '0));
        send_beat(pack_request(OP_INSERT, 3'd3, $urandom, $urandom, $urandom, 3'd6, 1'b0,
                               '0, '0));
        send_beat(pack_request(OP_INSERT, 3'd4, 32'h1, 32'h2, 32'h3, 3'd1, 1'b0, '0, '0));
        send_beat(pack_request(OP_CLEAR, 3'd5, '1, '1, '1, 3'd0, 1'b1, '1, '1));
        send_beat(pack_request(OP_CLEAR, 3'd0, '0, '0, '0, 3'd7, 1'b0, '0, '0));

        // Flood one MAC key chain past the probe limit
        drain_results();
        hold_request = 1'b1;
        for (int i = 0; i < 215; i++)
        begin
            logic [31:0] a;
            logic [31:0] b;
            a = $urandom;
            b = $urandom;
            send_beat(pack_request(OP_INSERT, 3'd4, a, b, hot_key ^ a ^ b,
                                   3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                   12'($urandom_range(0, 4095)),
                                   3'($urandom_range(0, 7))));
        end

        // Random traffic under several table settings
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_tables(1'b1, 1'b1);
                1: set_tables(1'b0, 1'b1);
                2: set_tables(1'b1, 1'b0);
                default: set_tables(1'b1, 1'b1);
            endcase
            for (int i = 0; i < 270; i++)
            begin
                random_beat(d);
                send_beat(d);
            end
        end
        set_tables(1'b0, 1'b0);
        send_beat(pack_request(OP_INSERT, 3'd2, $urandom, $urandom, $urandom, 3'd1,
                               1'b0, '0, '0));
        send_beat(pack_request(OP_CLEAR, 3'd0, '0, '0, '0, 3'd7, 1'b0, '0, '0));

        drain_results();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
